[rtl/core/task_table_scheduler_top_defines.svh]
// Assertion macros for the task table scheduler
`ifndef TASK_TABLE_SCHEDULER_TOP_DEFINES_SVH
`define TASK_TABLE_SCHEDULER_TOP_DEFINES_SVH

// check a property on every clock edge once reset is released
`define TTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every clock edge, reset included
`define TTS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tts_pkg.sv]
`timescale 1ns / 1ps
package tts_pkg;

    localparam int TASK_SLOTS_DEF  = 16;
    localparam int CPU_COUNT_DEF   = 4;
    localparam int QUEUE_COUNT_DEF = 4;

    // event codes
    typedef enum logic [2:0] {
        MODE_CREATE    = 3'd0,
        MODE_DISPATCH  = 3'd1,
        MODE_YIELD     = 3'd2,
        MODE_SLEEP     = 3'd3,
        MODE_SUSPEND   = 3'd4,
        MODE_WAKEUP    = 3'd5,
        MODE_TICK      = 3'd6,
        MODE_TERMINATE = 3'd7
    } t_mode;

    // result status codes
    typedef enum logic [2:0] {
        RES_OK         = 3'd0,
        RES_NO_SLOT    = 3'd1,
        RES_NOTHING    = 3'd2,
        RES_NO_CURRENT = 3'd3,
        RES_EMPTY      = 3'd4
    } t_res;

    // task states
    typedef enum logic [2:0] {
        TS_UNUSED     = 3'd0,
        TS_RUNNABLE   = 3'd1,
        TS_RUNNING    = 3'd2,
        TS_WAITING    = 3'd3,
        TS_TERMINATED = 3'd4
    } t_task_state;

    // controller states
    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_PREP,
        FSM_SCAN,
        FSM_FINISH,
        FSM_DONE
    } t_fsm;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input item
        logic prep;     // vacate CPU for dispatch, set scan start
        logic scan;     // examine one slot
        logic finish;   // apply single-step events
        logic emit;     // drive result strobe
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic needs_scan; // create, dispatch or tick
        logic scan_last;  // slot under scan is the last one
        logic scan_hit;   // create/dispatch found its slot
    } t_stat;

endpackage

[rtl/core/task_table_scheduler_top.sv]
`timescale 1ns / 1ps
// Sequence: an accepted item is captured, then yield, sleep, suspend, wakeup and terminate
// are applied in a single finish step; create and dispatch scan one slot per cycle until
// they hit or reach the last of TASK_SLOTS slots, and tick scans every slot.
// One item at a time: the next is taken at the earliest on the edge that takes the result;
// results cannot be stalled.
// Synchronous active-low reset empties the table, queues and CPUs.
module task_table_scheduler_top #(
    parameter int TASK_SLOTS  = tts_pkg::TASK_SLOTS_DEF,
    parameter int CPU_COUNT   = tts_pkg::CPU_COUNT_DEF,
    parameter int QUEUE_COUNT = tts_pkg::QUEUE_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mode,
    input  logic [1:0]         i_cpu,
    input  logic [1:0]         i_queue_id,
    input  logic [31:0]        i_tick_count,
    input  logic [31:0]        i_entry_address,
    input  logic signed [31:0] i_exit_value,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [3:0]         o_slot,
    output logic [31:0]        o_task_id,
    output logic [31:0]        o_start_address
);
    import tts_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // task table
    tts_dp #(
        .TASK_SLOTS  (TASK_SLOTS),
        .CPU_COUNT   (CPU_COUNT),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_mode          (i_mode),
        .i_cpu           (i_cpu),
        .i_queue_id      (i_queue_id),
        .i_tick_count    (i_tick_count),
        .i_entry_address (i_entry_address),
        .i_exit_value    (i_exit_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_task_id       (o_task_id),
        .o_start_address (o_start_address)
    );

endmodule

[rtl/core/tts_ctrl.sv]
`timescale 1ns / 1ps
module tts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tts_pkg::t_stat i_stat,
    output tts_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import tts_pkg::*;

    t_fsm r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            FSM_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = FSM_PREP;
                end
            end
            FSM_PREP: begin
                if (i_stat.needs_scan) begin
                    o_cmd.prep = 1'b1;
                    n_state    = FSM_SCAN;
                end else begin
                    n_state = FSM_FINISH;
                end
            end
            FSM_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit || i_stat.scan_last) begin
                    n_state = FSM_DONE;
                end
            end
            FSM_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = FSM_DONE;
            end
            FSM_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = FSM_IDLE;
            end
            default: n_state = FSM_IDLE;
        endcase
    end

endmodule

[rtl/core/tts_dp.sv]
`timescale 1ns / 1ps
module tts_dp #(
    parameter int TASK_SLOTS  = tts_pkg::TASK_SLOTS_DEF,
    parameter int CPU_COUNT   = tts_pkg::CPU_COUNT_DEF,
    parameter int QUEUE_COUNT = tts_pkg::QUEUE_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tts_pkg::t_cmd       i_cmd,
    output tts_pkg::t_stat      o_stat,
    input  logic [2:0]          i_mode,
    input  logic [1:0]          i_cpu,
    input  logic [1:0]          i_queue_id,
    input  logic [31:0]         i_tick_count,
    input  logic [31:0]         i_entry_address,
    input  logic signed [31:0]  i_exit_value,
    output logic                o_done,
    output logic [2:0]          o_status,
    output logic [3:0]          o_slot,
    output logic [31:0]         o_task_id,
    output logic [31:0]         o_start_address
);
    import tts_pkg::*;

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

    // bring a 2-bit code below a count by repeated compare and subtract
    function automatic logic [1:0] fold(input logic [1:0] v, input int unsigned m);
        logic [1:0] x;
        x = v;
        for (int k = 0; k < 3; k++) begin
            if (32'(x) >= m) x = x - 2'(m);
        end
        return x;
    endfunction

    // per-slot state; a link, head, tail or running value of none is the valid bit clear
    t_task_state         r_tstat [TASK_SLOTS];
    logic                r_aff_v [TASK_SLOTS];
    logic [CW-1:0]       r_aff   [TASK_SLOTS];
    logic [31:0]         r_ident [TASK_SLOTS];
    logic [31:0]         r_entry [TASK_SLOTS];
    logic [31:0]         r_ticks [TASK_SLOTS];
    logic                r_timed [TASK_SLOTS];
    logic [31:0]         r_exit  [TASK_SLOTS];
    logic                r_lnk_v [TASK_SLOTS];
    logic [SW-1:0]       r_lnk   [TASK_SLOTS];
    logic                r_hd_v  [QUEUE_COUNT];
    logic [SW-1:0]       r_hd    [QUEUE_COUNT];
    logic                r_tl_v  [QUEUE_COUNT];
    logic [SW-1:0]       r_tl    [QUEUE_COUNT];
    logic                r_run_v [CPU_COUNT];
    logic [SW-1:0]       r_run   [CPU_COUNT];
    logic [SW-1:0]       r_scanp [CPU_COUNT];
    logic [31:0]         r_last_id;

    // captured item
    t_mode               r_mode;
    logic [CW-1:0]       r_cpu;
    logic [QW-1:0]       r_q;
    logic [31:0]         r_n;
    logic [31:0]         r_entry_in;
    logic [31:0]         r_exit_in;

    // scan state
    logic [SW-1:0]       r_pos;
    logic [SW:0]         r_cnt;

    // result registers
    logic                r_done;
    t_res                r_res;
    logic [SW-1:0]       r_rslot;
    logic [31:0]         r_rid;
    logic [31:0]         r_raddr;

    logic          hit;
    logic [SW-1:0] pos_next;
    logic [SW-1:0] cur_slot;
    logic          cur_v;
    logic [SW-1:0] tl_slot;

    assign cur_v    = r_run_v[r_cpu];
    assign cur_slot = r_run[r_cpu];
    assign tl_slot  = r_tl[r_q];
    assign pos_next = (r_pos == SW'(TASK_SLOTS - 1)) ? '0 : r_pos + 1'b1;

    // slot examined this cycle matches the search
    always_comb begin
        hit = 1'b0;
        if (r_mode == MODE_CREATE) begin
            hit = (r_tstat[r_pos] == TS_UNUSED);
        end else if (r_mode == MODE_DISPATCH) begin
            hit = (r_tstat[r_pos] == TS_RUNNABLE) &&
                  (!r_aff_v[r_pos] || r_aff[r_pos] == r_cpu);
        end
    end

    assign o_stat.needs_scan = (r_mode == MODE_CREATE) || (r_mode == MODE_DISPATCH) ||
                               (r_mode == MODE_TICK);
    assign o_stat.scan_last  = (r_cnt == (SW+1)'(TASK_SLOTS - 1));
    assign o_stat.scan_hit   = hit;

    // control state of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_tstat[i] <= TS_UNUSED;
                r_aff_v[i] <= 1'b0;
                r_ident[i] <= '0;
                r_ticks[i] <= '0;
                r_timed[i] <= 1'b0;
                r_lnk_v[i] <= 1'b0;
            end
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                r_hd_v[i] <= 1'b0;
                r_tl_v[i] <= 1'b0;
            end
            for (int i = 0; i < CPU_COUNT; i++) begin
                r_run_v[i] <= 1'b0;
                r_scanp[i] <= '0;
            end
            r_last_id <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (i_cmd.load) begin
                r_mode     <= t_mode'(i_mode);
                r_cpu      <= CW'(fold(i_cpu, CPU_COUNT));
                r_q        <= QW'(fold(i_queue_id, QUEUE_COUNT));
                r_n        <= i_tick_count;
                r_entry_in <= i_entry_address;
                r_exit_in  <= i_exit_value;
            end
            // dispatch vacates the CPU; every scan starts here
            if (i_cmd.prep) begin
                r_cnt   <= '0;
                r_pos   <= (r_mode == MODE_DISPATCH) ? r_scanp[r_cpu] : '0;
                r_res   <= (r_mode == MODE_CREATE) ? RES_NO_SLOT :
                           (r_mode == MODE_DISPATCH) ? RES_NOTHING : RES_OK;
                r_rslot <= '0;
                r_rid   <= '0;
                r_raddr <= '0;
                if (r_mode == MODE_DISPATCH) begin
                    if (cur_v && r_tstat[cur_slot] == TS_RUNNING) begin
                        r_tstat[cur_slot] <= TS_RUNNABLE;
                    end
                    r_run_v[r_cpu] <= 1'b0;
                end
            end
            // one slot per cycle
            if (i_cmd.scan) begin
                r_cnt <= r_cnt + 1'b1;
                r_pos <= pos_next;
                if (r_mode == MODE_TICK) begin
                    if (r_tstat[r_pos] == TS_WAITING && r_timed[r_pos]) begin
                        if (r_ticks[r_pos] <= 32'd1) begin
                            r_ticks[r_pos] <= '0;
                            r_timed[r_pos] <= 1'b0;
                            r_tstat[r_pos] <= TS_RUNNABLE;
                        end else begin
                            r_ticks[r_pos] <= r_ticks[r_pos] - 1'b1;
                        end
                    end
                end else if (hit && r_mode == MODE_CREATE) begin
                    r_last_id      <= r_last_id + 1'b1;
                    r_ident[r_pos] <= r_last_id + 1'b1;
                    r_aff_v[r_pos] <= 1'b0;
                    r_ticks[r_pos] <= '0;
                    r_timed[r_pos] <= 1'b0;
                    r_lnk_v[r_pos] <= 1'b0;
                    r_tstat[r_pos] <= TS_RUNNABLE;
                    r_res          <= RES_OK;
                    r_rslot        <= r_pos;
                    r_rid          <= r_last_id + 1'b1;
                end else if (hit) begin
                    r_tstat[r_pos] <= TS_RUNNING;
                    r_aff_v[r_pos] <= 1'b1;
                    r_aff[r_pos]   <= r_cpu;
                    r_run_v[r_cpu] <= 1'b1;
                    r_run[r_cpu]   <= r_pos;
                    r_scanp[r_cpu] <= pos_next;
                    r_res          <= RES_OK;
                    r_rslot        <= r_pos;
                    r_rid          <= r_ident[r_pos];
                    r_raddr        <= r_entry[r_pos];
                end
            end
            // single-step events
            if (i_cmd.finish) begin
                r_raddr <= '0;
                if (r_mode == MODE_WAKEUP) begin
                    if (!r_hd_v[r_q]) begin
                        r_res   <= RES_EMPTY;
                        r_rslot <= '0;
                        r_rid   <= '0;
                    end else begin
                        r_hd_v[r_q] <= r_lnk_v[r_hd[r_q]];
                        r_hd[r_q]   <= r_lnk[r_hd[r_q]];
                        if (!r_lnk_v[r_hd[r_q]]) begin
                            r_tl_v[r_q] <= 1'b0;
                        end
                        r_lnk_v[r_hd[r_q]] <= 1'b0;
                        r_tstat[r_hd[r_q]] <= TS_RUNNABLE;
                        r_res   <= RES_OK;
                        r_rslot <= r_hd[r_q];
                        r_rid   <= r_ident[r_hd[r_q]];
                    end
                end else if (!cur_v) begin
                    r_res   <= RES_NO_CURRENT;
                    r_rslot <= '0;
                    r_rid   <= '0;
                end else begin
                    r_res   <= RES_OK;
                    r_rslot <= cur_slot;
                    r_rid   <= r_ident[cur_slot];
                    r_run_v[r_cpu] <= 1'b0;
                    unique case (r_mode)
                        MODE_SLEEP: begin
                            r_ticks[cur_slot] <= r_n;
                            r_timed[cur_slot] <= 1'b1;
                            r_tstat[cur_slot] <= TS_WAITING;
                        end
                        MODE_SUSPEND: begin
                            r_lnk_v[cur_slot] <= 1'b0;
                            r_timed[cur_slot] <= 1'b0;
                            r_tstat[cur_slot] <= TS_WAITING;
                            if (!r_tl_v[r_q]) begin
                                r_hd_v[r_q] <= 1'b1;
                                r_hd[r_q]   <= cur_slot;
                            end else begin
                                r_lnk_v[tl_slot] <= 1'b1;
                                r_lnk[tl_slot]   <= cur_slot;
                            end
                            r_tl_v[r_q] <= 1'b1;
                            r_tl[r_q]   <= cur_slot;
                        end
                        MODE_TERMINATE: begin
                            r_tstat[cur_slot] <= TS_TERMINATED;
                        end
                        default: begin
                            if (r_tstat[cur_slot] == TS_RUNNING) begin
                                r_tstat[cur_slot] <= TS_RUNNABLE;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // payload stores without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && hit && r_mode == MODE_CREATE) begin
            r_entry[r_pos] <= r_entry_in;
        end
        if (i_cmd.finish && r_mode == MODE_TERMINATE && cur_v) begin
            r_exit[cur_slot] <= r_exit_in;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_res;
    assign o_slot          = 4'(r_rslot);
    assign o_task_id       = r_rid;
    assign o_start_address = r_raddr;

endmodule

[rtl/core/tts_checker.sv]
`timescale 1ns / 1ps
`include "task_table_scheduler_top_defines.svh"
module tts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [2:0]  o_status,
    input logic [31:0] o_start_address
);
    import tts_pkg::*;

    // accepted item makes the block busy
    `TTS_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "busy not raised")
    // result strobe ends the busy period
    `TTS_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "done while busy")
    // strobe lasts one cycle
    `TTS_ASSERT(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done, "done held")
    // address only on a successful result
    `TTS_ASSERT(a_addr_ok, i_clk, i_rst_n,
        (o_done && o_status != RES_OK) |-> (o_start_address == 32'd0), "stray address")

endmodule

bind task_table_scheduler_top tts_checker u_tts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_start_address (o_start_address)
);

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
    import tts_pkg::*;

    localparam int NSLOT = 16;
    localparam int NCPU  = 4;
    localparam int NQ    = 4;
    localparam logic [4:0] NOBODY  = 5'h1f;
    localparam logic [2:0] ANY_CPU = 3'b100;
    localparam int QUIET_LIMIT = 600;

    // one expected scheduler result
    typedef struct {
        logic [2:0]  status;
        logic [3:0]  slot;
        logic [31:0] task_id;
        logic [31:0] start_address;
    } t_sched_result;

    // task table mirror and queue of expected results
    class t_sched_board;
        t_task_state  tstate[NSLOT];
        logic [2:0]   affinity[NSLOT];
        logic [31:0]  ident[NSLOT];
        logic [31:0]  entry[NSLOT];
        logic [31:0]  ticks[NSLOT];
        bit           timed[NSLOT];
        logic [4:0]   link[NSLOT];
        logic [4:0]   qhead[NQ];
        logic [4:0]   qtail[NQ];
        logic [4:0]   on_cpu[NCPU];
        logic [3:0]   scan_pos[NCPU];
        logic [31:0]  last_id;
        t_sched_result pending[$];
        int           errors;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                tstate[i] = TS_UNUSED;
                affinity[i] = ANY_CPU;
                ident[i] = '0;
                entry[i] = '0;
                ticks[i] = '0;
                timed[i] = 0;
                link[i] = NOBODY;
            end
            for (int i = 0; i < NQ; i++) begin
                qhead[i] = NOBODY;
                qtail[i] = NOBODY;
            end
            for (int i = 0; i < NCPU; i++) begin
                on_cpu[i] = NOBODY;
                scan_pos[i] = '0;
            end
            last_id = '0;
            errors = 0;
        endfunction

        // running task leaves the CPU
        function void vacate(int c);
            logic [4:0] s;
            s = on_cpu[c];
            if (s != NOBODY && tstate[s[3:0]] == TS_RUNNING)
                tstate[s[3:0]] = TS_RUNNABLE;
            on_cpu[c] = NOBODY;
        endfunction

        function void push(t_res st, int s, logic [31:0] id, logic [31:0] addr);
            t_sched_result r;
            r.status = st;
            r.slot = s[3:0];
            r.task_id = id;
            r.start_address = addr;
            pending.push_back(r);
        endfunction

        // accepted item: update the mirror and queue its result
        function void note(t_mode m, int c, int q, logic [31:0] n, logic [31:0] e);
            int s;
            int k;
            case (m)
                MODE_CREATE: begin
                    for (k = 0; k < NSLOT; k++)
                        if (tstate[k] == TS_UNUSED) break;
                    if (k == NSLOT) begin
                        push(RES_NO_SLOT, 0, '0, '0);
                    end else begin
                        last_id++;
                        ident[k] = last_id;
                        entry[k] = e;
                        affinity[k] = ANY_CPU;
                        ticks[k] = '0;
                        timed[k] = 0;
                        link[k] = NOBODY;
                        tstate[k] = TS_RUNNABLE;
                        push(RES_OK, k, last_id, '0);
                    end
                end
                MODE_DISPATCH: begin
                    vacate(c);
                    for (k = 0; k < NSLOT; k++) begin
                        s = (scan_pos[c] + k) % NSLOT;
                        if (tstate[s] == TS_RUNNABLE &&
                            (affinity[s] == ANY_CPU || affinity[s] == c)) break;
                    end
                    if (k == NSLOT) begin
                        push(RES_NOTHING, 0, '0, '0);
                    end else begin
                        tstate[s] = TS_RUNNING;
                        affinity[s] = c[2:0];
                        on_cpu[c] = s[4:0];
                        scan_pos[c] = (s + 1) % NSLOT;
                        push(RES_OK, s, ident[s], entry[s]);
                    end
                end
                MODE_WAKEUP: begin
                    if (qhead[q] == NOBODY) begin
                        push(RES_EMPTY, 0, '0, '0);
                    end else begin
                        s = qhead[q];
                        qhead[q] = link[s];
                        if (qhead[q] == NOBODY) qtail[q] = NOBODY;
                        link[s] = NOBODY;
                        tstate[s] = TS_RUNNABLE;
                        push(RES_OK, s, ident[s], '0);
                    end
                end
                MODE_TICK: begin
                    for (k = 0; k < NSLOT; k++)
                        if (tstate[k] == TS_WAITING && timed[k]) begin
                            if (ticks[k] <= 1) begin
                                ticks[k] = '0;
                                timed[k] = 0;
                                tstate[k] = TS_RUNNABLE;
                            end else begin
                                ticks[k]--;
                            end
                        end
                    push(RES_OK, 0, '0, '0);
                end
                default: begin
                    // yield, sleep, suspend, terminate
                    if (on_cpu[c] == NOBODY) begin
                        push(RES_NO_CURRENT, 0, '0, '0);
                    end else begin
                        s = on_cpu[c];
                        if (m == MODE_SLEEP) begin
                            ticks[s] = n;
                            timed[s] = 1;
                            tstate[s] = TS_WAITING;
                        end else if (m == MODE_SUSPEND) begin
                            link[s] = NOBODY;
                            timed[s] = 0;
                            tstate[s] = TS_WAITING;
                            if (qtail[q] == NOBODY) qhead[q] = s[4:0];
                            else link[qtail[q]] = s[4:0];
                            qtail[q] = s[4:0];
                        end else if (m == MODE_TERMINATE) begin
                            tstate[s] = TS_TERMINATED;
                        end
                        vacate(c);
                        push(RES_OK, s, ident[s], '0);
                    end
                end
            endcase
        endfunction

        // compare one result with the oldest expectation
        function void check(logic [2:0] st, logic [3:0] sl, logic [31:0] id,
                            logic [31:0] addr);
            t_sched_result x;
            if (pending.size() == 0) begin
                $error("result with nothing expected: status %0d slot %0d", st, sl);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (st !== x.status) begin
                $error("status expected %0d got %0d", x.status, st);
                errors++;
            end
            if (sl !== x.slot) begin
                $error("slot expected %0d got %0d", x.slot, sl);
                errors++;
            end
            if (id !== x.task_id) begin
                $error("task_id expected %0h got %0h", x.task_id, id);
                errors++;
            end
            if (addr !== x.start_address) begin
                $error("start_address expected %0h got %0h", x.start_address, addr);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [2:0]         i_mode = '0;
    logic [1:0]         i_cpu = '0;
    logic [1:0]         i_queue_id = '0;
    logic [31:0]        i_tick_count = '0;
    logic [31:0]        i_entry_address = '0;
    logic signed [31:0] i_exit_value = '0;
    logic               o_done;
    logic [2:0]         o_status;
    logic [3:0]         o_slot;
    logic [31:0]        o_task_id;
    logic [31:0]        o_start_address;

    t_sched_board board = new();
    int gap_pct = 0;
    int kills = 0;
    int quiet = 0;

    task_table_scheduler_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mode(i_mode), .i_cpu(i_cpu), .i_queue_id(i_queue_id),
        .i_tick_count(i_tick_count), .i_entry_address(i_entry_address),
        .i_exit_value(i_exit_value), .o_done(o_done), .o_status(o_status),
        .o_slot(o_slot), .o_task_id(o_task_id), .o_start_address(o_start_address)
    );

    always #10 i_clk = ~i_clk;

    // accepted items and results, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            board.note(t_mode'(i_mode), i_cpu, i_queue_id, i_tick_count, i_entry_address);
        if (i_rst_n && o_done)
            board.check(o_status, o_slot, o_task_id, o_start_address);
    end

    // watchdog on cycles with no progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // present one item and hold it until accepted
    task send_item(input t_mode m, input logic [1:0] c, input logic [1:0] q,
                   input logic [31:0] n, input logic [31:0] e, input logic [31:0] x);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= m;
        i_cpu <= c;
        i_queue_id <= q;
        i_tick_count <= n;
        i_entry_address <= e;
        i_exit_value <= x;
        do @(posedge i_clk); while (busy);
    endtask

    task drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    task random_item();
        int pick;
        t_mode m;
        logic [31:0] n;
        pick = $urandom_range(99);
        if (pick < 6) m = MODE_CREATE;
        else if (pick < 32) m = MODE_DISPATCH;
        else if (pick < 42) m = MODE_YIELD;
        else if (pick < 53) m = MODE_SLEEP;
        else if (pick < 65) m = MODE_SUSPEND;
        else if (pick < 81) m = MODE_WAKEUP;
        else if (pick < 96) m = MODE_TICK;
        else m = MODE_TERMINATE;
        // terminated slots are lost for good, so keep most of the table alive
        if (m == MODE_TERMINATE) begin
            if (kills >= 6) m = MODE_YIELD;
            else kills++;
        end
        n = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 4);
        send_item(m, $urandom_range(3), $urandom_range(3), n, $urandom(), $urandom());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table cases, then fill it and hit each event
        send_item(MODE_TICK, 2'd0, 2'd0, '0, '0, '0);
        send_item(MODE_DISPATCH, 2'd1, 2'd0, '0, '0, '0);
        send_item(MODE_YIELD, 2'd2, 2'd0, '0, '0, '0);
        send_item(MODE_WAKEUP, 2'd0, 2'd3, '0, '0, '0);
        send_item(MODE_CREATE, 2'd0, 2'd0, '0, 32'h0, '0);
        send_item(MODE_CREATE, 2'd3, 2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        for (int i = 2; i < 16; i++)
            send_item(MODE_CREATE, 2'd0, 2'd0, '0, $urandom(), '0);
        send_item(MODE_CREATE, 2'd0, 2'd0, '0, 32'h1234_5678, '0);
        send_item(MODE_DISPATCH, 2'd0, 2'd0, '0, '0, '0);
        send_item(MODE_DISPATCH, 2'd0, 2'd0, '0, '0, '0);
        send_item(MODE_SLEEP, 2'd0, 2'd0, 32'h0, '0, '0);
        send_item(MODE_DISPATCH, 2'd3, 2'd0, '0, '0, '0);
        send_item(MODE_SLEEP, 2'd3, 2'd0, 32'hffff_ffff, '0, '0);
        send_item(MODE_DISPATCH, 2'd1, 2'd0, '0, '0, '0);
        send_item(MODE_SUSPEND, 2'd1, 2'd3, '0, '0, '0);
        send_item(MODE_DISPATCH, 2'd2, 2'd0, '0, '0, '0);
        send_item(MODE_SUSPEND, 2'd2, 2'd3, '0, '0, '0);
        send_item(MODE_TICK, 2'd0, 2'd0, '0, '0, '0);
        send_item(MODE_WAKEUP, 2'd0, 2'd3, '0, '0, '0);
        send_item(MODE_DISPATCH, 2'd1, 2'd0, '0, '0, '0);
        send_item(MODE_YIELD, 2'd1, 2'd0, '0, '0, '0);
        send_item(MODE_DISPATCH, 2'd1, 2'd0, '0, '0, '0);
        send_item(MODE_TERMINATE, 2'd1, 2'd0, '0, '0, 32'h8000_0000);
        send_item(MODE_DISPATCH, 2'd2, 2'd0, '0, '0, '0);
        send_item(MODE_TERMINATE, 2'd2, 2'd0, '0, '0, 32'h7fff_ffff);
        kills = 2;

        // random phases with different sender gaps
        gap_pct = 16;
        repeat (136) random_item();
        drain();
        gap_pct = 45;
        repeat (136) random_item();
        drain();
        gap_pct = 0;
        repeat (136) random_item();

        drain();
        repeat (30) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
